### rtl/core/bsc_pkg.sv
`timescale 1ns / 1ps

package bsc_pkg;

  // Input item selector
  typedef enum logic [2:0] {
    MODE_MOVE   = 3'd0,
    MODE_STOP   = 3'd1,
    MODE_READ   = 3'd2,
    MODE_LIMIT  = 3'd3,
    MODE_MOTOR  = 3'd4,
    MODE_SLIDER = 3'd5,
    MODE_RX     = 3'd6
  } mode_t;

  // Result item kind
  typedef enum logic [1:0] {
    KIND_TX       = 2'd0,
    KIND_POS      = 2'd1,
    KIND_CSUM_ERR = 2'd2
  } kind_t;

  localparam logic [7:0]  HDR_BYTE   = 8'h55;
  localparam logic [7:0]  OP_MOVE    = 8'h01;
  localparam logic [7:0]  OP_STOP    = 8'h0C;
  localparam logic [7:0]  OP_LIMIT   = 8'h14;
  localparam logic [7:0]  OP_READ    = 8'h1C;
  localparam logic [7:0]  OP_MOTOR   = 8'h1D;
  localparam logic [7:0]  LEN_SHORT  = 8'h03;
  localparam logic [7:0]  LEN_LONG   = 8'h07;
  localparam logic [7:0]  LEN_REPLY  = 8'h05;
  localparam logic [7:0]  MOTOR_ON   = 8'h01;
  localparam logic [7:0]  MOTOR_PAD  = 8'h00;
  localparam logic [15:0] POS_MAX    = 16'd1000;
  localparam logic [15:0] TIME_MAX   = 16'd30000;
  localparam logic [14:0] TIME_MIN   = 15'd50;
  localparam int          DEG_FULL   = 240;
  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam int          PCT_SCALE  = 100;
  localparam logic [14:0] SLIDER_TIME_STEP = 15'(int'(TIME_MAX) / PCT_SCALE);

  // raw * 24 / 100 == (raw * 6) / 25; divide by 25 through a reciprocal
  localparam int          DEG_SHIFT  = 24;
  localparam logic [19:0] DEG_RECIP  = 20'd671089;

  localparam logic [7:0]  SERVO_ID_RESET = 8'd1;
  localparam int          QUEUE_DEPTH    = 4;

  // Slider percent to move position: (p * 240 / 100) * 1000 / 240, both truncated
  typedef logic [127:0][9:0] slider_tbl_t;

  function automatic slider_tbl_t build_slider_tbl();
    slider_tbl_t t;
    int          ang;
    t = '0;
    for (int i = 0; i <= PCT_SCALE; i++) begin
      ang  = (i * DEG_FULL) / PCT_SCALE;
      t[i] = 10'((ang * int'(POS_MAX)) / DEG_FULL);
    end
    return t;
  endfunction

  localparam slider_tbl_t SLIDER_POS = build_slider_tbl();

  // One job handed from the front to the back
  typedef struct packed {
    kind_t       kind;
    logic        long_pkt;
    logic [7:0]  opcode;
    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  p3;
    logic [15:0] raw;
    logic [13:0] deg;
  } job_t;

endpackage

### rtl/core/bsc_front.sv
`timescale 1ns / 1ps

module bsc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         servo_id,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [15:0]        in_target_position,
  input  logic [15:0]        in_move_time_ms,
  input  logic [15:0]        in_limit_min,
  input  logic [15:0]        in_limit_max,
  input  logic signed [15:0] in_motor_speed,
  input  logic signed [10:0] in_angle_percent,
  input  logic signed [10:0] in_speed_percent,
  input  logic [7:0]         in_rx_byte,
  input  logic               q_full,
  output logic               push,
  output bsc_pkg::job_t      job
);
  import bsc_pkg::*;

  typedef enum logic [7:0] {
    PH_HDR1 = 8'b0000_0001,
    PH_HDR2 = 8'b0000_0010,
    PH_ID   = 8'b0000_0100,
    PH_LEN  = 8'b0000_1000,
    PH_OP   = 8'b0001_0000,
    PH_LO   = 8'b0010_0000,
    PH_HI   = 8'b0100_0000,
    PH_SUM  = 8'b1000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] reply_pos_r, reply_pos_nxt;

  logic        produce;
  logic        accept;
  logic [6:0]  ang_pct;
  logic [6:0]  spd_pct;
  logic [15:0] slider_pos;
  logic [14:0] slider_time;
  logic [15:0] mv_pos;
  logic [15:0] mv_time;
  logic [7:0]  reply_sum;
  logic [18:0] deg_x;
  logic [38:0] deg_prod;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && produce;

  always_comb begin
    ang_pct = in_angle_percent[10] ? 7'd0 :
              (in_angle_percent > 11'(PCT_MAX) ? PCT_MAX : in_angle_percent[6:0]);
    spd_pct = in_speed_percent[10] ? 7'd0 :
              (in_speed_percent > 11'(PCT_MAX) ? PCT_MAX : in_speed_percent[6:0]);
    slider_pos  = 16'(SLIDER_POS[ang_pct]);
    slider_time = 15'(spd_pct) * SLIDER_TIME_STEP;
    if (slider_time < TIME_MIN) begin
      slider_time = TIME_MIN;
    end
  end

  // Position in degrees for a reply: (raw * 6) * recip(25)
  assign deg_x     = 19'({reply_pos_r, 2'b00}) + 19'({reply_pos_r, 1'b0});
  assign deg_prod  = 39'(deg_x) * 39'(DEG_RECIP);
  assign reply_sum = servo_id + LEN_REPLY + OP_READ + reply_pos_r[7:0] + reply_pos_r[15:8];

  always_comb begin
    job           = '0;
    job.kind      = KIND_TX;
    produce       = 1'b0;
    phase_nxt     = phase_r;
    reply_pos_nxt = reply_pos_r;
    mv_pos        = in_target_position;
    mv_time       = in_move_time_ms;
    if (mode_t'(in_mode) == MODE_SLIDER) begin
      mv_pos  = slider_pos;
      mv_time = 16'(slider_time);
    end
    case (mode_t'(in_mode))
      MODE_MOVE, MODE_SLIDER: begin
        job.long_pkt = 1'b1;
        job.opcode   = OP_MOVE;
        job.p0       = mv_pos[7:0];
        job.p1       = mv_pos[15:8];
        job.p2       = mv_time[7:0];
        job.p3       = mv_time[15:8];
        produce      = (mv_pos <= POS_MAX) && (mv_time <= TIME_MAX);
      end
      MODE_STOP: begin
        job.opcode = OP_STOP;
        produce    = 1'b1;
      end
      MODE_READ: begin
        job.opcode = OP_READ;
        produce    = 1'b1;
      end
      MODE_LIMIT: begin
        job.long_pkt = 1'b1;
        job.opcode   = OP_LIMIT;
        job.p0       = in_limit_min[7:0];
        job.p1       = in_limit_min[15:8];
        job.p2       = in_limit_max[7:0];
        job.p3       = in_limit_max[15:8];
        produce      = (in_limit_min < in_limit_max) && (in_limit_min <= POS_MAX)
                       && (in_limit_max <= POS_MAX);
      end
      MODE_MOTOR: begin
        job.long_pkt = 1'b1;
        job.opcode   = OP_MOTOR;
        job.p0       = MOTOR_ON;
        job.p1       = MOTOR_PAD;
        job.p2       = in_motor_speed[7:0];
        job.p3       = in_motor_speed[15:8];
        produce      = 1'b1;
      end
      MODE_RX: begin
        case (phase_r)
          PH_HDR1: if (in_rx_byte == HDR_BYTE) phase_nxt = PH_HDR2;
          PH_HDR2: phase_nxt = (in_rx_byte == HDR_BYTE) ? PH_ID : PH_HDR1;
          PH_ID:   phase_nxt = (in_rx_byte == servo_id) ? PH_LEN : PH_HDR1;
          PH_LEN:  phase_nxt = (in_rx_byte == LEN_REPLY) ? PH_OP : PH_HDR1;
          PH_OP:   phase_nxt = (in_rx_byte == OP_READ) ? PH_LO : PH_HDR1;
          PH_LO: begin
            reply_pos_nxt = {8'h00, in_rx_byte};
            phase_nxt     = PH_HI;
          end
          PH_HI: begin
            reply_pos_nxt = {in_rx_byte, reply_pos_r[7:0]};
            phase_nxt     = PH_SUM;
          end
          PH_SUM: begin
            phase_nxt = PH_HDR1;
            produce   = 1'b1;
            if (in_rx_byte == ~reply_sum) begin
              job.kind = KIND_POS;
              job.raw  = reply_pos_r;
              job.deg  = deg_prod[DEG_SHIFT+13:DEG_SHIFT];
            end else begin
              job.kind = KIND_CSUM_ERR;
            end
          end
          default: phase_nxt = PH_HDR1;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR1;
      reply_pos_r <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      reply_pos_r <= reply_pos_nxt;
    end
  end

endmodule

### rtl/core/bsc_queue.sv
`timescale 1ns / 1ps

module bsc_queue #(
  parameter int DEPTH = bsc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsc_pkg::job_t push_job,
  input  logic          pop,
  output bsc_pkg::job_t pop_job,
  output logic          not_empty,
  output logic          full
);
  import bsc_pkg::*;

  // DEPTH is a power of two, at least 2
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CW'(DEPTH));
  assign pop_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/core/bsc_back.sv
`timescale 1ns / 1ps

module bsc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    servo_id,
  input  logic          q_valid,
  input  bsc_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_tx_byte,
  output logic          out_last,
  output logic [15:0]   out_position_raw,
  output logic [13:0]   out_position_degrees
);
  import bsc_pkg::*;

  // Byte positions within a packet
  localparam logic [3:0] IDX_HDR1       = 4'd0;
  localparam logic [3:0] IDX_HDR2       = 4'd1;
  localparam logic [3:0] IDX_ID         = 4'd2;
  localparam logic [3:0] IDX_LEN        = 4'd3;
  localparam logic [3:0] IDX_OP         = 4'd4;
  localparam logic [3:0] IDX_P0         = 4'd5;
  localparam logic [3:0] IDX_P1         = 4'd6;
  localparam logic [3:0] IDX_P2         = 4'd7;
  localparam logic [3:0] IDX_P3         = 4'd8;
  localparam logic [3:0] IDX_CSUM_SHORT = 4'd5;
  localparam logic [3:0] IDX_CSUM_LONG  = 4'd9;

  logic        busy_r;
  job_t        cur_r;
  logic [3:0]  idx_r;
  logic [7:0]  sum_r;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_tx_r;
  logic        out_last_r;
  logic [15:0] out_raw_r;
  logic [13:0] out_deg_r;

  logic        adv;
  logic        is_csum;
  logic        done;
  logic [7:0]  pkt_byte;

  assign adv     = busy_r && (!out_valid_r || out_ready);
  assign is_csum = (idx_r == (cur_r.long_pkt ? IDX_CSUM_LONG : IDX_CSUM_SHORT));
  assign done    = adv && ((cur_r.kind != KIND_TX) || is_csum);
  assign pop     = q_valid && (!busy_r || done);

  always_comb begin
    if (is_csum) begin
      pkt_byte = ~sum_r;
    end else begin
      case (idx_r)
        IDX_HDR1, IDX_HDR2: pkt_byte = HDR_BYTE;
        IDX_ID:             pkt_byte = servo_id;
        IDX_LEN:            pkt_byte = cur_r.long_pkt ? LEN_LONG : LEN_SHORT;
        IDX_OP:             pkt_byte = cur_r.opcode;
        IDX_P0:             pkt_byte = cur_r.p0;
        IDX_P1:             pkt_byte = cur_r.p1;
        IDX_P2:             pkt_byte = cur_r.p2;
        IDX_P3:             pkt_byte = cur_r.p3;
        default:            pkt_byte = '0;
      endcase
    end
  end

  // Job sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_job;
      idx_r <= IDX_HDR1;
      sum_r <= '0;
    end else if (adv) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r >= IDX_ID) begin
        sum_r <= sum_r + pkt_byte;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r <= cur_r.kind;
      if (cur_r.kind == KIND_TX) begin
        out_tx_r   <= pkt_byte;
        out_last_r <= is_csum;
        out_raw_r  <= '0;
        out_deg_r  <= '0;
      end else begin
        out_tx_r   <= '0;
        out_last_r <= 1'b1;
        out_raw_r  <= cur_r.raw;
        out_deg_r  <= cur_r.deg;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_tx_byte          = out_tx_r;
  assign out_last             = out_last_r;
  assign out_position_raw     = out_raw_r;
  assign out_position_degrees = out_deg_r;

endmodule

### rtl/core/bus_servo_command_framer.sv
`timescale 1ns / 1ps
// Host-side framer for a serial bus servo link.
//
// Input channel (in_valid/in_ready): one beat is either a command request
// (move, stop, read position, angle limit, motor mode, slider) or one byte
// received from the bus, chosen by in_mode. Commands with out-of-range
// arguments and the unused mode are accepted and dropped.
// Output channel (out_valid/out_ready): one beat per packet byte (kind 0),
// with out_last on the checksum byte, or one beat per reply report
// (kind 1 position, kind 2 checksum error), always with out_last set.
// Config channel (cfg_valid/cfg_ready): writes the servo bus id; write it
// only while no work is in flight. cfg_ready is always high.
// Results pass the queue, job and output registers. Throughput: a packet
// streams one byte per cycle unless stalled, 6 beats for stop/read and 10
// beats for the long packets; a report is one beat. The output stage sets
// the pace; a queue of QUEUE_DEPTH jobs sits between classifier and framer.
// Reset: queue emptied, reply matcher waits for a first header, id is 1.
// When the receiver stalls the output beat holds; the queue fills and then
// in_ready drops until the framer drains a job.
module bus_servo_command_framer #(
  parameter int QUEUE_DEPTH = bsc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [15:0]        in_target_position,
  input  logic [15:0]        in_move_time_ms,
  input  logic [15:0]        in_limit_min,
  input  logic [15:0]        in_limit_max,
  input  logic signed [15:0] in_motor_speed,
  input  logic signed [10:0] in_angle_percent,
  input  logic signed [10:0] in_speed_percent,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_last,
  output logic [15:0]        out_position_raw,
  output logic [13:0]        out_position_degrees
);
  import bsc_pkg::*;

  logic [7:0] servo_id_r;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_not_empty;
  job_t       push_job;
  job_t       pop_job;

  // Servo id register; taken whenever the write beat shows
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_id_r <= SERVO_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      servo_id_r <= cfg_data;
    end
  end

  // Front: accept beats, check arguments, run the reply matcher, build jobs
  bsc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .servo_id           (servo_id_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_target_position (in_target_position),
    .in_move_time_ms    (in_move_time_ms),
    .in_limit_min       (in_limit_min),
    .in_limit_max       (in_limit_max),
    .in_motor_speed     (in_motor_speed),
    .in_angle_percent   (in_angle_percent),
    .in_speed_percent   (in_speed_percent),
    .in_rx_byte         (in_rx_byte),
    .q_full             (q_full),
    .push               (q_push),
    .job                (push_job)
  );

  // Job queue: decouple classification from byte streaming
  bsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back: stream packet bytes with running checksum, or emit a report
  bsc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .servo_id             (servo_id_r),
    .q_valid              (q_not_empty),
    .q_job                (pop_job),
    .pop                  (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_tx_byte          (out_tx_byte),
    .out_last             (out_last),
    .out_position_raw     (out_position_raw),
    .out_position_degrees (out_position_degrees)
  );

endmodule

### rtl/core/bsc_checker.sv
`timescale 1ns / 1ps

module bsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_tx_byte,
  input logic        out_last,
  input logic [15:0] out_position_raw,
  input logic [13:0] out_position_degrees
);
  import bsc_pkg::*;

  // Hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_tx_byte) && $stable(out_last))
    else $error("stalled output beat changed");

  // Reports are single beats with no packet byte
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_POS || out_kind == KIND_CSUM_ERR)
      |-> out_last && (out_tx_byte == 8'h00))
    else $error("report beat malformed");

  // Only a position report carries position data
  a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TX || out_kind == KIND_CSUM_ERR)
      |-> (out_position_raw == 16'h0000) && (out_position_degrees == 14'h0000))
    else $error("position data on a non-position beat");

  // A packet byte that follows a finished packet is a header byte
  a_next_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last && (out_kind == KIND_TX)
      |=> !out_valid || (out_kind != KIND_TX) || (out_tx_byte == HDR_BYTE))
    else $error("packet does not open with a header");

  // Result kind is one of the three codes
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_TX) || (out_kind == KIND_POS)
      || (out_kind == KIND_CSUM_ERR))
    else $error("illegal result kind");

endmodule

bind bus_servo_command_framer bsc_checker u_bsc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_kind             (out_kind),
  .out_tx_byte          (out_tx_byte),
  .out_last             (out_last),
  .out_position_raw     (out_position_raw),
  .out_position_degrees (out_position_degrees)
);
